[sv/bbcm_pkg.sv]
// types and constants of the block buffer cache manager
// no dependencies
package bbcm_pkg;

   localparam logic [7:0] MISS_SYNC_LIMIT_RESET = 8'd20;
   localparam int TAG_W = 56;

   localparam logic [2:0] ACT_ACQUIRE     = 3'd0;
   localparam logic [2:0] ACT_RELEASE     = 3'd1;
   localparam logic [2:0] ACT_MARK_VALID  = 3'd2;
   localparam logic [2:0] ACT_MARK_DIRTY  = 3'd3;
   localparam logic [2:0] ACT_SYNC_DEVICE = 3'd4;
   localparam logic [2:0] ACT_SYNC_SOME   = 3'd5;

   localparam logic [2:0] ERR_OK          = 3'd0;
   localparam logic [2:0] ERR_DEV_ZERO    = 3'd1;
   localparam logic [2:0] ERR_UNREF       = 3'd2;
   localparam logic [2:0] ERR_NONE_FREE   = 3'd3;
   localparam logic [2:0] ERR_SLOT_UNUSED = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW    = 3'd5;

   localparam logic [7:0] REF_MAX = 8'd255;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LK_RD,
      ST_LK_CMP,
      ST_ALLOC_RD,
      ST_ALLOC,
      ST_SY_STEP,
      ST_SY_DATA,
      ST_SD_STEP,
      ST_SD_DATA,
      ST_REL_DATA,
      ST_FINAL
   } state_type;

endpackage

[sv/bbcm_intf.sv]
// request and result channel interfaces of the buffer cache manager
// no dependencies
interface bbcm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] dev;
   logic [31:0] blk;
   logic [4:0]  slot;
   logic [7:0]  count;
   modport source (output valid, action, dev, blk, slot, count, input ready);
   modport sink (input valid, action, dev, blk, slot, count, output ready);
endinterface

interface bbcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  slot_res;
   logic        hit;
   logic        valid_res;
   logic        is_writeback;
   logic [15:0] dev_res;
   logic [31:0] blk_res;
   logic [5:0]  freed;
   logic [2:0]  error;
   logic        last;
   modport source (output valid, slot_res, hit, valid_res, is_writeback, dev_res, blk_res,
                   freed, error, last, input ready);
   modport sink (input valid, slot_res, hit, valid_res, is_writeback, dev_res, blk_res,
                 freed, error, last, output ready);
endinterface

[sv/bbcm_ram.sv]
// generic single write port ram with registered read
// no dependencies
module bbcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/block_buffer_cache_manager_top.sv]
// block buffer cache manager: slot tags, reference counts, free fifo and sync scans
// depends on bbcm_pkg, bbcm_intf (bbcm_req_if, bbcm_rsp_if) and bbcm_ram
//
// channel   dir  handshake                 payload
// req_bus   in   valid/ready               action dev blk slot count
// rsp_bus   out  valid/ready               slot_res hit valid_res is_writeback
//                                          dev_res blk_res freed error last
// csr_*     in   apb write on psel&penable miss_sync_limit at byte 0
//                &pwrite&pready
//
// one request at a time; ready only while the sequencer is idle
// acquire lookup reads the tag ram slot by slot, a read state then a compare state for each
// sync scans step through the slots; a slot that is read adds a data state, which holds on rsp
// a result waits in the output register; a scan holds its next write-back while it is not taken
// reset is synchronous; no clearing pass, tag ram reads are guarded by in-use flags
module block_buffer_cache_manager_top
   import bbcm_pkg::*;
#(
   parameter int NUM_BUFFERS = 32
) (
   input  logic        clock,
   input  logic        reset,
   bbcm_req_if.sink    req_bus,
   bbcm_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IDX_W = $clog2(NUM_BUFFERS);
   localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
   localparam int SUM_W = CNT_W + 1;

   state_type state_ff, state_in;

   logic [7:0] miss_sync_limit_ff;

   logic [NUM_BUFFERS-1:0] in_use_ff, in_use_in;
   logic [NUM_BUFFERS-1:0] dirty_ff, dirty_in;
   logic [NUM_BUFFERS-1:0] valid_ff, valid_in;
   logic [NUM_BUFFERS-1:0] fq_vld_ff, fq_vld_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fr_ff, fr_in;
   logic             sync_acq_ff, sync_acq_in;

   logic [2:0]  act_ff;
   logic [15:0] dev_ff;
   logic [31:0] blk_ff;
   logic [4:0]  slot_ff;
   logic [7:0]  lim_ff, lim_in;

   logic [4:0] res_slot_ff, res_slot_in;
   logic       res_hit_ff, res_hit_in;
   logic       res_val_ff, res_val_in;
   logic [2:0] res_err_ff, res_err_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic        rsp_val_ff, rsp_val_in;
   logic        rsp_wb_ff, rsp_wb_in;
   logic [15:0] rsp_dev_ff, rsp_dev_in;
   logic [31:0] rsp_blk_ff, rsp_blk_in;
   logic [5:0]  rsp_fr_ff, rsp_fr_in;
   logic [2:0]  rsp_err_ff, rsp_err_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_load;

   logic             tag_we, tag_re;
   logic [IDX_W-1:0] tag_wa, tag_ra;
   logic [TAG_W-1:0] tag_wd, tag_rd;
   logic             fq_we, fq_re;
   logic [IDX_W-1:0] fq_wa, fq_rd;
   logic [IDX_W-1:0] fq_data;

   logic [15:0] rd_dev;
   logic [31:0] rd_blk;
   logic [7:0]  rd_cnt;

   logic             req_fire, out_free, slot_bad, lk_match, lk_last;
   logic [IDX_W-1:0] req_idx, cur_idx, pos_next, alloc_idx, tail_idx;
   logic [SUM_W-1:0] tail_sum;
   logic             sy_wb, sd_wb, idx_done;

   bbcm_ram #(.WIDTH(TAG_W), .DEPTH(NUM_BUFFERS)) u_tag_ram (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_wa), .wr_data(tag_wd),
      .rd_en(tag_re), .rd_addr(tag_ra), .rd_data(tag_rd)
   );

   bbcm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_free_ram (
      .clock(clock), .wr_en(fq_we), .wr_addr(fq_wa), .wr_data(fq_data),
      .rd_en(fq_re), .rd_addr(head_ff), .rd_data(fq_rd)
   );

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, miss_sync_limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_sync_limit_ff <= MISS_SYNC_LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == 2'd0) begin
         miss_sync_limit_ff <= csr_pwdata[7:0];
      end
   end

   // shared decode
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign rd_dev = tag_rd[55:40];
   assign rd_blk = tag_rd[39:8];
   assign rd_cnt = tag_rd[7:0];
   assign req_idx = IDX_W'(req_bus.slot);
   assign slot_bad = ({3'd0, req_bus.slot} >= 8'(NUM_BUFFERS)) || !in_use_ff[req_idx];
   assign cur_idx = idx_ff[IDX_W-1:0];
   assign idx_done = (idx_ff == CNT_W'(NUM_BUFFERS));
   assign lk_match = in_use_ff[cur_idx] && rd_dev == dev_ff && rd_blk == blk_ff;
   assign lk_last = (idx_ff == CNT_W'(NUM_BUFFERS - 1));
   assign pos_next = (pos_ff == IDX_W'(NUM_BUFFERS - 1)) ? '0 : pos_ff + IDX_W'(1);
   assign alloc_idx = fq_vld_ff[head_ff] ? fq_rd : head_ff;
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(free_cnt_ff);
   assign tail_idx = (tail_sum >= SUM_W'(NUM_BUFFERS)) ?
                     IDX_W'(tail_sum - SUM_W'(NUM_BUFFERS)) : IDX_W'(tail_sum);
   assign sy_wb = dirty_ff[pos_ff] && valid_ff[pos_ff];
   assign sd_wb = (rd_dev == dev_ff);

   // freed slot written into the free fifo is the scan position or the request slot
   assign fq_data = (state_ff == ST_SD_DATA) ? cur_idx :
                    (state_ff == ST_REL_DATA) ? IDX_W'(slot_ff) : pos_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.action)
                  ACT_ACQUIRE:     state_in = (req_bus.dev == '0) ? ST_FINAL : ST_LK_RD;
                  ACT_RELEASE:     state_in = slot_bad ? ST_FINAL : ST_REL_DATA;
                  ACT_MARK_VALID:  state_in = ST_FINAL;
                  ACT_MARK_DIRTY:  state_in = ST_FINAL;
                  ACT_SYNC_DEVICE: state_in = (req_bus.dev == '0) ? ST_FINAL : ST_SD_STEP;
                  ACT_SYNC_SOME:   state_in = ST_SY_STEP;
                  default:         state_in = ST_IDLE;
               endcase
            end
         end
         ST_LK_RD: state_in = ST_LK_CMP;
         ST_LK_CMP: begin
            if (lk_match) begin
               state_in = ST_FINAL;
            end else if (lk_last) begin
               state_in = (free_cnt_ff == '0) ? ST_SY_STEP : ST_ALLOC_RD;
            end else begin
               state_in = ST_LK_RD;
            end
         end
         ST_ALLOC_RD: state_in = ST_ALLOC;
         ST_ALLOC:    state_in = ST_FINAL;
         ST_SY_STEP: begin
            if (idx_done) begin
               state_in = (sync_acq_ff && free_cnt_ff != '0) ? ST_ALLOC_RD : ST_FINAL;
            end else if (in_use_ff[pos_next]) begin
               state_in = ST_SY_DATA;
            end
         end
         ST_SY_DATA: begin
            if (!(sy_wb && !out_free)) begin
               state_in = ST_SY_STEP;
            end
         end
         ST_SD_STEP: begin
            if (idx_done) begin
               state_in = ST_FINAL;
            end else if (in_use_ff[cur_idx] && dirty_ff[cur_idx] && valid_ff[cur_idx]) begin
               state_in = ST_SD_DATA;
            end
         end
         ST_SD_DATA: begin
            if (!(sd_wb && !out_free)) begin
               state_in = ST_SD_STEP;
            end
         end
         ST_REL_DATA: state_in = ST_FINAL;
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      in_use_in   = in_use_ff;
      dirty_in    = dirty_ff;
      valid_in    = valid_ff;
      fq_vld_in   = fq_vld_ff;
      head_in     = head_ff;
      free_cnt_in = free_cnt_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      fr_in       = fr_ff;
      sync_acq_in = sync_acq_ff;
      lim_in      = lim_ff;
      res_slot_in = res_slot_ff;
      res_hit_in  = res_hit_ff;
      res_val_in  = res_val_ff;
      res_err_in  = res_err_ff;
      rsp_load    = 1'b0;
      rsp_slot_in = '0;
      rsp_hit_in  = 1'b0;
      rsp_val_in  = 1'b0;
      rsp_wb_in   = 1'b0;
      rsp_dev_in  = '0;
      rsp_blk_in  = '0;
      rsp_fr_in   = '0;
      rsp_err_in  = ERR_OK;
      rsp_last_in = 1'b0;
      tag_we = 1'b0;
      tag_wa = cur_idx;
      tag_wd = {dev_ff, blk_ff, rd_cnt};
      tag_re = 1'b0;
      tag_ra = cur_idx;
      fq_we  = 1'b0;
      fq_wa  = tail_idx;
      fq_re  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in = '0;
               fr_in = '0;
               sync_acq_in = 1'b0;
               res_slot_in = req_bus.slot;
               res_hit_in = 1'b0;
               res_val_in = 1'b0;
               res_err_in = ERR_OK;
               unique case (req_bus.action)
                  ACT_ACQUIRE, ACT_SYNC_DEVICE: begin
                     res_slot_in = '0;
                     if (req_bus.dev == '0) begin
                        res_err_in = ERR_DEV_ZERO;
                     end
                  end
                  ACT_RELEASE: begin
                     if (slot_bad) begin
                        res_err_in = ERR_SLOT_UNUSED;
                     end else begin
                        tag_re = 1'b1;
                        tag_ra = req_idx;
                     end
                  end
                  ACT_MARK_VALID: begin
                     if (slot_bad) begin
                        res_err_in = ERR_SLOT_UNUSED;
                     end else begin
                        valid_in[req_idx] = 1'b1;
                     end
                  end
                  ACT_MARK_DIRTY: begin
                     if (slot_bad) begin
                        res_err_in = ERR_SLOT_UNUSED;
                     end else begin
                        dirty_in[req_idx] = 1'b1;
                     end
                  end
                  ACT_SYNC_SOME: begin
                     res_slot_in = '0;
                     lim_in = (req_bus.count > 8'(NUM_BUFFERS)) ?
                              8'(NUM_BUFFERS - 1) : req_bus.count;
                  end
                  default: ;
               endcase
            end
         end
         ST_LK_RD: begin
            tag_re = 1'b1;
         end
         ST_LK_CMP: begin
            if (lk_match) begin
               res_slot_in = 5'(cur_idx);
               res_hit_in = 1'b1;
               res_val_in = valid_ff[cur_idx];
               if (rd_cnt == REF_MAX) begin
                  res_err_in = ERR_OVERFLOW;
               end else begin
                  tag_we = 1'b1;
                  tag_wd = {dev_ff, blk_ff, rd_cnt + 8'd1};
               end
            end else if (lk_last) begin
               idx_in = '0;
               sync_acq_in = 1'b1;
               lim_in = (miss_sync_limit_ff > 8'(NUM_BUFFERS)) ?
                        8'(NUM_BUFFERS - 1) : miss_sync_limit_ff;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_ALLOC_RD: begin
            fq_re = 1'b1;
         end
         ST_ALLOC: begin
            tag_we = 1'b1;
            tag_wa = alloc_idx;
            tag_wd = {dev_ff, blk_ff, 8'd1};
            in_use_in[alloc_idx] = 1'b1;
            dirty_in[alloc_idx] = 1'b0;
            valid_in[alloc_idx] = 1'b0;
            head_in = (head_ff == IDX_W'(NUM_BUFFERS - 1)) ? '0 : head_ff + IDX_W'(1);
            free_cnt_in = free_cnt_ff - CNT_W'(1);
            res_slot_in = 5'(alloc_idx);
         end
         ST_SY_STEP: begin
            if (idx_done) begin
               if (sync_acq_ff && free_cnt_ff == '0) begin
                  res_err_in = ERR_NONE_FREE;
               end
            end else begin
               pos_in = pos_next;
               idx_in = idx_ff + CNT_W'(1);
               if (in_use_ff[pos_next]) begin
                  tag_re = 1'b1;
                  tag_ra = pos_next;
               end
            end
         end
         ST_SY_DATA: begin
            if (!(sy_wb && !out_free)) begin
               if (sy_wb) begin
                  rsp_load = 1'b1;
                  rsp_slot_in = 5'(pos_ff);
                  rsp_wb_in = 1'b1;
                  rsp_dev_in = rd_dev;
                  rsp_blk_in = rd_blk;
                  dirty_in[pos_ff] = 1'b0;
               end
               if (rd_cnt == '0) begin
                  in_use_in[pos_ff] = 1'b0;
                  dirty_in[pos_ff] = 1'b0;
                  valid_in[pos_ff] = 1'b0;
                  if (free_cnt_ff < CNT_W'(NUM_BUFFERS)) begin
                     fq_we = 1'b1;
                     fq_wa = tail_idx;
                     fq_vld_in[tail_idx] = 1'b1;
                     free_cnt_in = free_cnt_ff + CNT_W'(1);
                  end
                  fr_in = fr_ff + CNT_W'(1);
                  if (8'(fr_ff) >= lim_ff) begin
                     idx_in = CNT_W'(NUM_BUFFERS);
                  end
               end
            end
         end
         ST_SD_STEP: begin
            if (!idx_done) begin
               if (in_use_ff[cur_idx] && dirty_ff[cur_idx] && valid_ff[cur_idx]) begin
                  tag_re = 1'b1;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         ST_SD_DATA: begin
            if (!(sd_wb && !out_free)) begin
               idx_in = idx_ff + CNT_W'(1);
               if (sd_wb) begin
                  rsp_load = 1'b1;
                  rsp_slot_in = 5'(cur_idx);
                  rsp_wb_in = 1'b1;
                  rsp_dev_in = rd_dev;
                  rsp_blk_in = rd_blk;
                  dirty_in[cur_idx] = 1'b0;
                  if (rd_cnt == '0) begin
                     in_use_in[cur_idx] = 1'b0;
                     valid_in[cur_idx] = 1'b0;
                     if (free_cnt_ff < CNT_W'(NUM_BUFFERS)) begin
                        fq_we = 1'b1;
                        fq_wa = tail_idx;
                        fq_vld_in[tail_idx] = 1'b1;
                        free_cnt_in = free_cnt_ff + CNT_W'(1);
                     end
                     fr_in = fr_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_REL_DATA: begin
            if (rd_cnt == '0) begin
               res_err_in = ERR_UNREF;
            end else begin
               tag_we = 1'b1;
               tag_wa = IDX_W'(slot_ff);
               tag_wd = {rd_dev, rd_blk, rd_cnt - 8'd1};
               if (rd_cnt == 8'd1 &&
                   !(dirty_ff[IDX_W'(slot_ff)] && valid_ff[IDX_W'(slot_ff)])) begin
                  in_use_in[IDX_W'(slot_ff)] = 1'b0;
                  dirty_in[IDX_W'(slot_ff)] = 1'b0;
                  valid_in[IDX_W'(slot_ff)] = 1'b0;
                  if (free_cnt_ff < CNT_W'(NUM_BUFFERS)) begin
                     fq_we = 1'b1;
                     fq_wa = tail_idx;
                     fq_vld_in[tail_idx] = 1'b1;
                     free_cnt_in = free_cnt_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_slot_in = res_slot_ff;
               rsp_hit_in = res_hit_ff;
               rsp_val_in = res_val_ff;
               rsp_fr_in = 6'(fr_ff);
               rsp_err_in = res_err_ff;
               rsp_last_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         dirty_ff     <= '0;
         valid_ff     <= '0;
         fq_vld_ff    <= '0;
         head_ff      <= '0;
         free_cnt_ff  <= CNT_W'(NUM_BUFFERS);
         pos_ff       <= '0;
         idx_ff       <= '0;
         fr_ff        <= '0;
         sync_acq_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         dirty_ff     <= dirty_in;
         valid_ff     <= valid_in;
         fq_vld_ff    <= fq_vld_in;
         head_ff      <= head_in;
         free_cnt_ff  <= free_cnt_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         fr_ff        <= fr_in;
         sync_acq_ff  <= sync_acq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff  <= req_bus.action;
         dev_ff  <= req_bus.dev;
         blk_ff  <= req_bus.blk;
         slot_ff <= req_bus.slot;
      end
      lim_ff      <= lim_in;
      res_slot_ff <= res_slot_in;
      res_hit_ff  <= res_hit_in;
      res_val_ff  <= res_val_in;
      res_err_ff  <= res_err_in;
      if (rsp_load) begin
         rsp_slot_ff <= rsp_slot_in;
         rsp_hit_ff  <= rsp_hit_in;
         rsp_val_ff  <= rsp_val_in;
         rsp_wb_ff   <= rsp_wb_in;
         rsp_dev_ff  <= rsp_dev_in;
         rsp_blk_ff  <= rsp_blk_in;
         rsp_fr_ff   <= rsp_fr_in;
         rsp_err_ff  <= rsp_err_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.slot_res     = rsp_slot_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.valid_res    = rsp_val_ff;
   assign rsp_bus.is_writeback = rsp_wb_ff;
   assign rsp_bus.dev_res      = rsp_dev_ff;
   assign rsp_bus.blk_res      = rsp_blk_ff;
   assign rsp_bus.freed        = rsp_fr_ff;
   assign rsp_bus.error        = rsp_err_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // assertions
   a_wb_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wb_ff |-> !rsp_last_ff)
      else $error("write-back result marked last");
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= CNT_W'(NUM_BUFFERS))
      else $error("free count above pool size");
   a_wb_source: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_wb_in |-> (state_ff == ST_SY_DATA || state_ff == ST_SD_DATA))
      else $error("write-back outside a sync scan");
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_last_in |=> state_ff == ST_IDLE && act_ff == $past(act_ff))
      else $error("sequencer busy after final result");
endmodule
